>>> sv/pixel_color_converter_assert.svh
// Assertion macros used by the checker file.
`ifndef PIXEL_COLOR_CONVERTER_ASSERT_SVH
`define PIXEL_COLOR_CONVERTER_ASSERT_SVH

// Clocked check, switched off while reset is held.
`define PCC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("pcc check failed");

// Clocked check that also covers the reset cycles.
`define PCC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("pcc check failed");

`endif

>>> sv/pcc_pkg.sv
package pcc_pkg;

    localparam int SMP_W = 16;          // port sample width
    localparam int DEN_W = 18;          // 3 * in_max
    localparam int Q_W   = 16;          // gray quotient bits
    localparam int NUM_W = DEN_W + Q_W; // dividend / remainder width

    typedef logic [SMP_W-1:0] t_smp;
    typedef logic [DEN_W-1:0] t_den;
    typedef logic [Q_W-1:0]   t_quot;
    typedef logic [NUM_W-1:0] t_num;
    typedef logic [2:0]       t_mode;
    typedef logic [1:0]       t_chan;
    typedef logic [1:0]       t_reg_idx;

    localparam t_mode MODE_BITMAP  = 3'd0;
    localparam t_mode MODE_GRAY    = 3'd1;
    localparam t_mode MODE_ISOLATE = 3'd2;
    localparam t_mode MODE_REMOVE  = 3'd3;
    localparam t_mode MODE_SEPIA   = 3'd4;

    localparam t_chan CH_RED   = 2'd0;
    localparam t_chan CH_GREEN = 2'd1;
    localparam t_chan CH_BLUE  = 2'd2;

    localparam t_reg_idx REG_MODE     = 2'd0;
    localparam t_reg_idx REG_CHANNEL  = 2'd1;
    localparam t_reg_idx REG_IN_MAX   = 2'd2;
    localparam t_reg_idx REG_GRAY_MAX = 2'd3;

    localparam int Q_SHIFT = 10;

    // Sepia matrix, Q10, row = output channel
    localparam logic [9:0] SEPIA_COEF [0:2][0:2] = '{
        '{10'd402, 10'd787, 10'd194},
        '{10'd357, 10'd702, 10'd172},
        '{10'd279, 10'd547, 10'd134}
    };

    // Payload that rides along the divider chain
    typedef struct packed {
        t_smp red;
        t_smp green;
        t_smp blue;
        t_smp level;
        logic gray;   // level comes from the quotient
        logic ovf;    // quotient is at least 2^Q_W
    } t_item;

endpackage

>>> sv/pcc_front.sv
module pcc_front #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  pcc_pkg::t_smp   i_red,
    input  pcc_pkg::t_smp   i_green,
    input  pcc_pkg::t_smp   i_blue,
    input  pcc_pkg::t_mode  i_mode,
    input  pcc_pkg::t_chan  i_channel,
    input  pcc_pkg::t_smp   i_in_max,
    input  pcc_pkg::t_smp   i_gray_max,
    input  pcc_pkg::t_den   i_den,
    output logic            o_valid,
    input  logic            i_ready,
    output pcc_pkg::t_num   o_rem,
    output pcc_pkg::t_item  o_item
);

    localparam int SW     = pcc_pkg::SMP_W;
    localparam int SUM_W  = SAMPLE_BITS + 2;
    localparam int PROD_W = SUM_W + SW;
    localparam int ACC_W  = SAMPLE_BITS + 11;
    localparam int SHR_W  = ACC_W - pcc_pkg::Q_SHIFT;
    localparam int LIM_W  = SW + 1;
    localparam int BM_W   = SUM_W + 2;
    localparam int NW     = pcc_pkg::NUM_W;
    localparam logic [LIM_W-1:0] SMP_MASK = LIM_W'((64'd1 << SAMPLE_BITS) - 64'd1);

    logic                   rdy_a, rdy_b, rdy_c;
    logic [SAMPLE_BITS-1:0] px_in [0:2];

    logic                   r_a_valid;
    logic [SAMPLE_BITS-1:0] r_a_px [0:2];

    logic                   r_b_valid;
    logic [SAMPLE_BITS-1:0] r_b_px [0:2];
    logic [SUM_W-1:0]       r_b_sum;
    logic [PROD_W-1:0]      r_b_prod;
    logic [ACC_W-1:0]       r_b_acc [0:2];
    logic [SUM_W-1:0]       n_b_sum;
    logic [PROD_W-1:0]      n_b_prod;
    logic [ACC_W-1:0]       n_b_acc [0:2];

    logic                   r_c_valid;
    pcc_pkg::t_num          r_c_rem;
    pcc_pkg::t_item         r_c_item;
    pcc_pkg::t_item         n_c_item;

    logic [LIM_W-1:0]       lim;
    logic [LIM_W-1:0]       sep [0:2];
    logic [SHR_W-1:0]       shr;
    pcc_pkg::t_smp          px_ext [0:2];
    logic                   dark;

    assign rdy_c   = !r_c_valid || i_ready;
    assign rdy_b   = !r_b_valid || rdy_c;
    assign rdy_a   = !r_a_valid || rdy_b;
    assign o_ready = rdy_a;
    assign o_valid = r_c_valid;
    assign o_rem   = r_c_rem;
    assign o_item  = r_c_item;

    assign px_in[0] = i_red[SAMPLE_BITS-1:0];
    assign px_in[1] = i_green[SAMPLE_BITS-1:0];
    assign px_in[2] = i_blue[SAMPLE_BITS-1:0];

    // stage B: sum, gray product, sepia accumulations
    always_comb begin
        n_b_sum  = SUM_W'(r_a_px[0]) + SUM_W'(r_a_px[1]) + SUM_W'(r_a_px[2]);
        n_b_prod = PROD_W'(n_b_sum) * PROD_W'(i_gray_max);
        for (int c = 0; c < 3; c++) begin
            n_b_acc[c] = ACC_W'(pcc_pkg::SEPIA_COEF[c][0]) * ACC_W'(r_a_px[0])
                       + ACC_W'(pcc_pkg::SEPIA_COEF[c][1]) * ACC_W'(r_a_px[1])
                       + ACC_W'(pcc_pkg::SEPIA_COEF[c][2]) * ACC_W'(r_a_px[2]);
        end
    end

    // stage C: clamp, threshold, mode select
    always_comb begin
        shr = '0;
        lim = (LIM_W'(i_in_max) > SMP_MASK) ? SMP_MASK : LIM_W'(i_in_max);
        for (int c = 0; c < 3; c++) begin
            shr       = r_b_acc[c][ACC_W-1:pcc_pkg::Q_SHIFT];
            sep[c]    = (LIM_W'(shr) > lim) ? lim : LIM_W'(shr);
            px_ext[c] = SW'(r_b_px[c]);
        end
        dark = (BM_W'(r_b_sum) << 1) < (BM_W'(i_in_max) + (BM_W'(i_in_max) << 1));

        n_c_item = '0;
        case (i_mode)
            pcc_pkg::MODE_BITMAP: begin
                n_c_item.level = SW'(dark);
            end
            pcc_pkg::MODE_GRAY: begin
                n_c_item.gray = 1'b1;
                n_c_item.ovf  = NW'(r_b_prod) >= (NW'(i_den) << pcc_pkg::Q_W);
            end
            pcc_pkg::MODE_ISOLATE: begin
                n_c_item.red   = (i_channel == pcc_pkg::CH_RED)   ? px_ext[0] : '0;
                n_c_item.green = (i_channel == pcc_pkg::CH_GREEN) ? px_ext[1] : '0;
                n_c_item.blue  = (i_channel == pcc_pkg::CH_BLUE)  ? px_ext[2] : '0;
            end
            pcc_pkg::MODE_REMOVE: begin
                n_c_item.red   = (i_channel == pcc_pkg::CH_RED)   ? '0 : px_ext[0];
                n_c_item.green = (i_channel == pcc_pkg::CH_GREEN) ? '0 : px_ext[1];
                n_c_item.blue  = (i_channel == pcc_pkg::CH_BLUE)  ? '0 : px_ext[2];
            end
            pcc_pkg::MODE_SEPIA: begin
                n_c_item.red   = SW'(sep[0]);
                n_c_item.green = SW'(sep[1]);
                n_c_item.blue  = SW'(sep[2]);
            end
            default: begin
                n_c_item = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (rdy_a) begin
                r_a_valid <= i_valid;
            end
            if (rdy_b) begin
                r_b_valid <= r_a_valid;
            end
            if (rdy_c) begin
                r_c_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_a) begin
            r_a_px <= px_in;
        end
        if (rdy_b) begin
            r_b_px   <= r_a_px;
            r_b_sum  <= n_b_sum;
            r_b_prod <= n_b_prod;
            r_b_acc  <= n_b_acc;
        end
        if (rdy_c) begin
            r_c_rem  <= NW'(r_b_prod);
            r_c_item <= n_c_item;
        end
    end

endmodule

>>> sv/pcc_div_cell.sv
module pcc_div_cell #(
    parameter int BIT = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  pcc_pkg::t_num   i_rem,
    input  pcc_pkg::t_quot  i_quot,
    input  pcc_pkg::t_item  i_item,
    input  pcc_pkg::t_den   i_den,
    output logic            o_valid,
    input  logic            i_ready,
    output pcc_pkg::t_num   o_rem,
    output pcc_pkg::t_quot  o_quot,
    output pcc_pkg::t_item  o_item
);

    localparam int NW = pcc_pkg::NUM_W;

    logic            r_valid;
    pcc_pkg::t_num   r_rem;
    pcc_pkg::t_quot  r_quot;
    pcc_pkg::t_item  r_item;
    pcc_pkg::t_num   shifted;
    logic            fits;
    pcc_pkg::t_num   n_rem;
    pcc_pkg::t_quot  n_quot;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_quot  = r_quot;
    assign o_item  = r_item;

    // one restoring step: quotient bit BIT
    always_comb begin
        shifted     = NW'(i_den) << BIT;
        fits        = i_rem >= shifted;
        n_rem       = fits ? (i_rem - shifted) : i_rem;
        n_quot      = i_quot;
        n_quot[BIT] = fits;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_rem  <= n_rem;
            r_quot <= n_quot;
            r_item <= i_item;
        end
    end

endmodule

>>> sv/pixel_color_converter.sv
// Pixel colour converter. One RGB pixel per transaction in, one converted
// pixel per transaction out, in order; a new pixel can be taken every clock
// cycle unless the pipeline is stalled. A pixel passes three front stages
// (capture, products, mode select), a row of 16 divider cells that each
// resolve one bit of the grey quotient, and the output register. Every stage
// has its own valid bit and stalls only when the stage after it is full, so
// bubbles close up and input is still taken while a result waits. The
// registers are written through i_cfg_we/i_cfg_idx/i_cfg_wdata and must only
// be changed while the block holds no pixel.
module pixel_color_converter #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // in_red, in_green, in_blue
    // master side
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // out_red, out_green, out_blue, out_level
    // register writes: 0 mode, 1 channel, 2 in_max, 3 gray_max
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_wdata
);

    localparam int NCELL = pcc_pkg::Q_W;

    pcc_pkg::t_mode  r_mode;
    pcc_pkg::t_chan  r_channel;
    pcc_pkg::t_smp   r_in_max;
    pcc_pkg::t_smp   r_gray_max;
    pcc_pkg::t_smp   max_nz;
    pcc_pkg::t_den   den;

    logic            c_valid [0:NCELL];
    logic            c_ready [0:NCELL];
    pcc_pkg::t_num   c_rem   [0:NCELL];
    pcc_pkg::t_quot  c_quot  [0:NCELL];
    pcc_pkg::t_item  c_item  [0:NCELL];

    logic            r_m_valid;
    logic [63:0]     r_m_data;
    logic            m_load;
    pcc_pkg::t_smp   level;
    pcc_pkg::t_item  last;

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= pcc_pkg::MODE_BITMAP;
            r_channel  <= pcc_pkg::CH_RED;
            r_in_max   <= 16'd255;
            r_gray_max <= 16'd255;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pcc_pkg::REG_MODE:     r_mode     <= i_cfg_wdata[2:0];
                pcc_pkg::REG_CHANNEL:  r_channel  <= i_cfg_wdata[1:0];
                pcc_pkg::REG_IN_MAX:   r_in_max   <= i_cfg_wdata;
                pcc_pkg::REG_GRAY_MAX: r_gray_max <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // grey divisor 3*in_max; a zero maximum divides as one
    assign max_nz = (r_in_max == '0) ? pcc_pkg::t_smp'(1) : r_in_max;
    assign den    = pcc_pkg::t_den'(max_nz) + (pcc_pkg::t_den'(max_nz) << 1);

    pcc_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_tvalid),
        .o_ready    (o_s_tready),
        .i_red      (i_s_tdata[15:0]),
        .i_green    (i_s_tdata[31:16]),
        .i_blue     (i_s_tdata[47:32]),
        .i_mode     (r_mode),
        .i_channel  (r_channel),
        .i_in_max   (r_in_max),
        .i_gray_max (r_gray_max),
        .i_den      (den),
        .o_valid    (c_valid[0]),
        .i_ready    (c_ready[0]),
        .o_rem      (c_rem[0]),
        .o_item     (c_item[0])
    );

    assign c_quot[0] = '0;

    // divider row, most significant quotient bit first
    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        pcc_div_cell #(
            .BIT (NCELL - 1 - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[k]),
            .o_ready (c_ready[k]),
            .i_rem   (c_rem[k]),
            .i_quot  (c_quot[k]),
            .i_item  (c_item[k]),
            .i_den   (den),
            .o_valid (c_valid[k+1]),
            .i_ready (c_ready[k+1]),
            .o_rem   (c_rem[k+1]),
            .o_quot  (c_quot[k+1]),
            .o_item  (c_item[k+1])
        );
    end

    // output register; grey level saturates at gray_max
    assign m_load         = !r_m_valid || i_m_tready;
    assign c_ready[NCELL] = m_load;
    assign last           = c_item[NCELL];

    always_comb begin
        level = last.level;
        if (last.gray) begin
            if (last.ovf || (c_quot[NCELL] > r_gray_max)) begin
                level = r_gray_max;
            end else begin
                level = c_quot[NCELL];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (m_load) begin
            r_m_valid <= c_valid[NCELL];
        end
    end

    always_ff @(posedge i_clk) begin
        if (m_load) begin
            r_m_data <= {level, last.blue, last.green, last.red};
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

endmodule

>>> sv/pcc_checker.sv
`include "pixel_color_converter_assert.svh"

module pcc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [47:0] i_s_tdata,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [63:0] o_m_tdata,
    input logic        i_cfg_we,
    input logic [1:0]  i_cfg_idx,
    input logic [15:0] i_cfg_wdata
);

    // no result straight after reset
    `PCC_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_m_tvalid)

    // a stalled result holds
    `PCC_ASSERT(a_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))

    // colour and level never both carry data
    `PCC_ASSERT(a_excl, i_clk, i_rst_n, o_m_tvalid |-> (o_m_tdata[63:48] == 16'd0) || (o_m_tdata[47:0] == 48'd0))

    // an empty or draining output never blocks the input
    `PCC_ASSERT(a_flow, i_clk, i_rst_n, !o_m_tvalid || i_m_tready |-> o_s_tready)

endmodule

bind pixel_color_converter pcc_checker u_pcc_checker (.*);

>>> tb/pixel_color_converter_test.sv
`timescale 1ns / 1ps

// Pixel colour converter testbench.
// Directed rows first (reset state, extremes, every mode and channel, odd
// register values), then random pixels under several register settings.
// Each output transaction is compared field by field with the oldest pixel
// result predicted at input acceptance.
module pixel_color_converter_test;

    localparam int LATENCY   = 20;
    localparam int MAX_CYCLE = 400000;

    typedef struct packed {
        pcc_pkg::t_smp red;
        pcc_pkg::t_smp green;
        pcc_pkg::t_smp blue;
        pcc_pkg::t_smp level;
    } t_pix_out;

    // one row of the directed table; chk says the typed result is to be used
    typedef struct {
        pcc_pkg::t_smp r;
        pcc_pkg::t_smp g;
        pcc_pkg::t_smp b;
        logic          chk;
        t_pix_out      res;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [47:0] i_s_tdata = '0;   // in_red, in_green, in_blue
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [63:0] o_m_tdata;        // out_red, out_green, out_blue, out_level
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [15:0] i_cfg_wdata = '0;

    pixel_color_converter uut (.*);

    always #2 i_clk = ~i_clk;

    // shadow copy of the configuration registers
    pcc_pkg::t_mode cfg_mode     = pcc_pkg::MODE_BITMAP;
    pcc_pkg::t_chan cfg_chan     = pcc_pkg::CH_RED;
    pcc_pkg::t_smp  cfg_in_max   = 16'd255;
    pcc_pkg::t_smp  cfg_gray_max = 16'd255;

    t_pix_out pending_pix[$];
    int       errors = 0;
    int       cycles = 0;
    int       src_idle_pct = 0;
    int       snk_idle_pct = 0;
    bit       snk_hold = 1'b0;
    int       snk_hold_len = 0;

    function automatic t_pix_out convert_pixel(pcc_pkg::t_smp r, pcc_pkg::t_smp g,
                                               pcc_pkg::t_smp b);
        t_pix_out      o;
        logic [17:0]   sum;
        logic [63:0]   q;
        logic [63:0]   den;
        logic [31:0]   acc;
        logic [31:0]   px [0:2];
        pcc_pkg::t_smp col [0:2];
        o = '0;
        px[0] = 32'(r); px[1] = 32'(g); px[2] = 32'(b);
        sum = 18'(r) + 18'(g) + 18'(b);
        col[0] = '0; col[1] = '0; col[2] = '0;
        case (cfg_mode)
            pcc_pkg::MODE_BITMAP:
                o.level = ({sum, 1'b0} >= 3 * {2'b0, cfg_in_max}) ? 16'd0 : 16'd1;
            pcc_pkg::MODE_GRAY: begin
                den = 3 * ((cfg_in_max == 0) ? 64'd1 : 64'(cfg_in_max));
                q = (64'(sum) * 64'(cfg_gray_max)) / den;
                if (q > 64'(cfg_gray_max)) q = 64'(cfg_gray_max);
                o.level = q[15:0];
            end
            pcc_pkg::MODE_ISOLATE, pcc_pkg::MODE_REMOVE: begin
                for (int c = 0; c < 3; c++)
                    col[c] = ((c == cfg_chan) == (cfg_mode == pcc_pkg::MODE_ISOLATE))
                             ? px[c][15:0] : 16'd0;
            end
            pcc_pkg::MODE_SEPIA: begin
                for (int c = 0; c < 3; c++) begin
                    acc = '0;
                    for (int k = 0; k < 3; k++)
                        acc += 32'(pcc_pkg::SEPIA_COEF[c][k]) * px[k];
                    acc = acc >> pcc_pkg::Q_SHIFT;
                    if (acc > 32'(cfg_in_max)) acc = 32'(cfg_in_max);
                    col[c] = acc[15:0];
                end
            end
            default: ;
        endcase
        o.red = col[0]; o.green = col[1]; o.blue = col[2];
        return o;
    endfunction

    // cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLE) begin
            $display("pixel_color_converter_test: done, errors");
            $finish;
        end
    end

    // output side: random stall, optional long hold-off
    always @(posedge i_clk) begin
        if (snk_hold_len > 0) begin
            snk_hold_len <= snk_hold_len - 1;
            i_m_tready <= 1'b0;
        end else if (snk_hold) begin
            snk_hold_len <= 300;
            snk_hold <= 1'b0;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= i_rst_n && ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // result check
    always @(posedge i_clk) begin
        t_pix_out got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = {o_m_tdata[15:0], o_m_tdata[31:16], o_m_tdata[47:32], o_m_tdata[63:48]};
            if (pending_pix.size() == 0) begin
                $error("unexpected result %h", got);
                errors++;
            end else begin
                want = pending_pix.pop_front();
                if (got.red !== want.red) begin
                    $error("out_red exp %0d got %0d", want.red, got.red); errors++;
                end
                if (got.green !== want.green) begin
                    $error("out_green exp %0d got %0d", want.green, got.green); errors++;
                end
                if (got.blue !== want.blue) begin
                    $error("out_blue exp %0d got %0d", want.blue, got.blue); errors++;
                end
                if (got.level !== want.level) begin
                    $error("out_level exp %0d got %0d", want.level, got.level); errors++;
                end
            end
        end
    end

    task automatic write_reg(pcc_pkg::t_reg_idx idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            pcc_pkg::REG_MODE:     cfg_mode     = val[2:0];
            pcc_pkg::REG_CHANNEL:  cfg_chan     = val[1:0];
            pcc_pkg::REG_IN_MAX:   cfg_in_max   = val;
            pcc_pkg::REG_GRAY_MAX: cfg_gray_max = val;
            default: ;
        endcase
    endtask

    task automatic drain_pixels();
        while (pending_pix.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // one input transaction; prediction is queued at acceptance
    task automatic send_pixel(pcc_pkg::t_smp r, pcc_pkg::t_smp g, pcc_pkg::t_smp b,
                              logic chk, t_pix_out res);
        t_pix_out p;
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {b, g, r};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        p = convert_pixel(r, g, b);
        if (chk && p !== res) begin
            $error("directed row exp %h predictor %h", res, p);
            errors++;
        end
        pending_pix.push_back(p);
    endtask

    task automatic set_regs(pcc_pkg::t_mode m, pcc_pkg::t_chan c, pcc_pkg::t_smp mx,
                            pcc_pkg::t_smp gm);
        drain_pixels();
        write_reg(pcc_pkg::REG_MODE, 16'(m));
        write_reg(pcc_pkg::REG_CHANNEL, 16'(c));
        write_reg(pcc_pkg::REG_IN_MAX, mx);
        write_reg(pcc_pkg::REG_GRAY_MAX, gm);
    endtask

    // skew toward extremes now and then
    function automatic pcc_pkg::t_smp rand_sample();
        case ($urandom_range(7))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return pcc_pkg::t_smp'($urandom_range(cfg_in_max));
            default: return pcc_pkg::t_smp'($urandom);
        endcase
    endfunction

    task automatic random_run(int n);
        for (int i = 0; i < n; i++) begin
            if (i == n / 2) begin
                // source pauses until the block is empty
                i_s_tvalid <= 1'b0;
                while (pending_pix.size() != 0) @(posedge i_clk);
            end
            send_pixel(rand_sample(), rand_sample(), rand_sample(), 1'b0, '0);
        end
        i_s_tvalid <= 1'b0;
    endtask

    t_row rows [$];

    initial begin
        pcc_pkg::t_mode m;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset state: bitmap, in_max 255
        rows = '{
            '{16'd0,     16'd0,     16'd0,     1'b1, '{0, 0, 0, 1}},
            '{16'd255,   16'd255,   16'd255,   1'b1, '{0, 0, 0, 0}},
            '{16'd128,   16'd127,   16'd127,   1'b1, '{0, 0, 0, 1}},
            '{16'd128,   16'd128,   16'd127,   1'b1, '{0, 0, 0, 0}},
            '{16'hFFFF,  16'hFFFF,  16'hFFFF,  1'b1, '{0, 0, 0, 0}}
        };
        foreach (rows[i]) send_pixel(rows[i].r, rows[i].g, rows[i].b, rows[i].chk, rows[i].res);
        i_s_tvalid <= 1'b0;

        // grayscale, saturating above in_max and zero in_max
        set_regs(pcc_pkg::MODE_GRAY, pcc_pkg::CH_RED, 16'd255, 16'd255);
        rows = '{
            '{16'd255,   16'd255,   16'd255,   1'b1, '{0, 0, 0, 255}},
            '{16'hFFFF,  16'hFFFF,  16'hFFFF,  1'b1, '{0, 0, 0, 255}},
            '{16'd100,   16'd50,    16'd7,     1'b0, '0}
        };
        foreach (rows[i]) send_pixel(rows[i].r, rows[i].g, rows[i].b, rows[i].chk, rows[i].res);
        i_s_tvalid <= 1'b0;
        set_regs(pcc_pkg::MODE_GRAY, pcc_pkg::CH_RED, 16'd0, 16'hFFFF);
        send_pixel(16'd1, 16'd1, 16'd0, 1'b0, '0);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, '{0, 0, 0, 16'hFFFF});
        i_s_tvalid <= 1'b0;
        set_regs(pcc_pkg::MODE_BITMAP, pcc_pkg::CH_RED, 16'd0, 16'd1);
        send_pixel(16'd0, 16'd0, 16'd0, 1'b1, '{0, 0, 0, 0});
        i_s_tvalid <= 1'b0;

        // isolate / remove for every channel value, including three
        for (int c = 0; c < 4; c++) begin
            set_regs(pcc_pkg::MODE_ISOLATE, pcc_pkg::t_chan'(c), 16'd255, 16'd255);
            send_pixel(16'h1234, 16'hABCD, 16'hFFFF, 1'b0, '0);
            i_s_tvalid <= 1'b0;
            set_regs(pcc_pkg::MODE_REMOVE, pcc_pkg::t_chan'(c), 16'd255, 16'd255);
            send_pixel(16'h1234, 16'hABCD, 16'hFFFF, 1'b0, '0);
            i_s_tvalid <= 1'b0;
        end

        // sepia clamping at both ends of in_max; blue row stays below full scale
        set_regs(pcc_pkg::MODE_SEPIA, pcc_pkg::CH_RED, 16'hFFFF, 16'd255);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, '{16'hFFFF, 16'hFFFF, 16'hEFFF, 0});
        send_pixel(16'd1000, 16'd200, 16'd30, 1'b0, '0);
        i_s_tvalid <= 1'b0;
        set_regs(pcc_pkg::MODE_SEPIA, pcc_pkg::CH_RED, 16'd0, 16'd255);
        send_pixel(16'd500, 16'd500, 16'd500, 1'b1, '{0, 0, 0, 0});
        i_s_tvalid <= 1'b0;

        // unused mode codes give all zero
        set_regs(pcc_pkg::t_mode'(3'd7), pcc_pkg::CH_RED, 16'd255, 16'd255);
        send_pixel(16'd9, 16'd9, 16'd9, 1'b1, '{0, 0, 0, 0});
        i_s_tvalid <= 1'b0;

        // random part in three idling phases
        for (int ph = 0; ph < 3; ph++) begin
            src_idle_pct = (ph == 0) ? 17 : (ph == 1) ? 48 : 0;
            snk_idle_pct = (ph == 0) ? 48 : (ph == 1) ? 17 : 0;
            for (int s = 0; s < 4; s++) begin
                m = pcc_pkg::t_mode'($urandom_range(7));
                if ($urandom_range(3) != 0) m = pcc_pkg::t_mode'($urandom_range(4));
                case ($urandom_range(3))
                    0: set_regs(m, pcc_pkg::t_chan'($urandom_range(3)), 16'hFFFF, 16'd1);
                    1: set_regs(m, pcc_pkg::t_chan'($urandom_range(3)), 16'd1, 16'hFFFF);
                    default: set_regs(m, pcc_pkg::t_chan'($urandom_range(3)),
                                      pcc_pkg::t_smp'($urandom), pcc_pkg::t_smp'($urandom));
                endcase
                if (ph == 2 && s == 0) snk_hold = 1'b1;   // long receiver hold-off
                random_run(65);
            end
        end

        drain_pixels();
        if (errors == 0)
            $display("pixel_color_converter_test: done, clean");
        else
            $display("pixel_color_converter_test: done, errors");
        $finish;
    end
endmodule

>>> pixel_color_converter.f
+incdir+sv
sv/pcc_pkg.sv
sv/pcc_front.sv
sv/pcc_div_cell.sv
sv/pixel_color_converter.sv
sv/pcc_checker.sv
tb/pixel_color_converter_test.sv
